// ===== hdl/pli_pkg.sv =====
// Shared types and constants for the piecewise linear interpolator.
`timescale 1ns / 1ps

package pli_pkg;

	// Width of one Q16.16 value.
	localparam int unsigned VAL_W = 32;
	// Width of the input item payload: index, x, y and query, padded to bytes.
	localparam int unsigned IN_DATA_W = 104;
	// Width of the breakpoint count on the configuration port.
	localparam int unsigned CNT_W = 5;
	// Number of quotient bits, one per divider step.
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// Input item kinds carried in tuser.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// Table read address selection.
	typedef enum logic [1:0] {
		ADDR_LAST = 2'd0,
		ADDR_ZERO = 2'd1,
		ADDR_ONE  = 2'd2,
		ADDR_NEXT = 2'd3
	} addr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      wr_en;
		logic      cap_query;
		addr_sel_t addr_sel;
		logic      take_clamp;
		logic      scan_start;
		logic      scan_step;
		logic      scan_stop;
		logic      diff;
		logic      mul;
		logic      div_step;
		logic      finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_valid;
		logic is_eval;
		logic ge_last;
		logic le_first;
		logic scan_done;
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage

// ===== hdl/pli_ctrl.sv =====
// Controller state machine for the piecewise linear interpolator.
`timescale 1ns / 1ps

module pli_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  pli_pkg::sts_t sts,
	output pli_pkg::cmd_t cmd,
	output logic          in_ready
);

	typedef enum logic [7:0] {
		ST_IDLE      = 8'b0000_0001,
		ST_CHK_LAST  = 8'b0000_0010,
		ST_CHK_FIRST = 8'b0000_0100,
		ST_SCAN      = 8'b0000_1000,
		ST_DIFF      = 8'b0001_0000,
		ST_MUL       = 8'b0010_0000,
		ST_DIV       = 8'b0100_0000,
		ST_FIN       = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.addr_sel = pli_pkg::ADDR_NEXT;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (sts.in_valid) begin
					if (sts.is_eval) begin
						cmd.cap_query = 1'b1;
						cmd.addr_sel  = pli_pkg::ADDR_LAST;
						state_d       = ST_CHK_LAST;
					end else begin
						cmd.wr_en = 1'b1;
					end
				end
			end
			ST_CHK_LAST: begin
				cmd.addr_sel = pli_pkg::ADDR_ZERO;
				if (sts.ge_last) begin
					cmd.take_clamp = 1'b1;
					state_d        = ST_FIN;
				end else begin
					state_d = ST_CHK_FIRST;
				end
			end
			ST_CHK_FIRST: begin
				cmd.addr_sel = pli_pkg::ADDR_ONE;
				if (sts.le_first) begin
					cmd.take_clamp = 1'b1;
					state_d        = ST_FIN;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					cmd.scan_stop = 1'b1;
					state_d       = ST_DIFF;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/pli_datapath.sv =====
// Datapath of the piecewise linear interpolator: tables, scan, multiply, divide.
`timescale 1ns / 1ps

module pli_datapath #(
	parameter int unsigned MAX_POINTS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic [pli_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pli_pkg::VAL_W-1:0]       m_tdata,
	input  logic                            cfg_valid,
	input  logic [pli_pkg::CNT_W-1:0]       cfg_data,
	input  pli_pkg::cmd_t                   cmd,
	output pli_pkg::sts_t                   sts
);

	localparam int unsigned IDX_W = $clog2(MAX_POINTS);
	localparam int unsigned W     = pli_pkg::VAL_W;

	// Input item fields.
	logic        [3:0]   in_index;
	logic signed [W-1:0] in_x;
	logic signed [W-1:0] in_y;
	logic signed [W-1:0] in_query;

	assign in_index = s_tdata[3:0];
	assign in_x     = s_tdata[35:4];
	assign in_y     = s_tdata[67:36];
	assign in_query = s_tdata[99:68];

	// Breakpoint tables.
	logic signed [W-1:0] x_mem [MAX_POINTS];
	logic signed [W-1:0] y_mem [MAX_POINTS];
	logic signed [W-1:0] rd_x_q;
	logic signed [W-1:0] rd_y_q;
	logic [IDX_W-1:0]    rd_addr;
	logic [IDX_W-1:0]    wr_addr;
	logic                wr_ok;

	// Control and working registers.
	logic [IDX_W-1:0]    last_q;
	logic [IDX_W-1:0]    last_d;
	logic [IDX_W-1:0]    idx_q;
	logic signed [W-1:0] query_q;
	logic signed [W-1:0] prev_x_q;
	logic signed [W-1:0] prev_y_q;
	logic signed [W-1:0] cur_x_q;
	logic signed [W-1:0] cur_y_q;
	logic [W-1:0]        num_q;
	logic [W-1:0]        den_q;
	logic [W-1:0]        mag_q;
	logic                neg_q;
	logic [W-1:0]        rem_q;
	logic [W-1:0]        dvd_q;
	logic [pli_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [W-1:0]        res_q;
	logic                out_valid_q;

	// Differences for the chosen segment.
	logic [W:0] num_w;
	logic [W:0] den_w;
	logic [W:0] dy_w;
	logic [W:0] mag_w;

	// One restoring division step.
	logic [W:0] trial;
	logic       fits;

	assign wr_addr = IDX_W'(in_index);
	assign wr_ok   = (32'(in_index) < MAX_POINTS);

	// Read address selection.
	always_comb begin
		case (cmd.addr_sel)
			pli_pkg::ADDR_LAST: rd_addr = last_q;
			pli_pkg::ADDR_ZERO: rd_addr = '0;
			pli_pkg::ADDR_ONE:  rd_addr = IDX_W'(1);
			pli_pkg::ADDR_NEXT: rd_addr = idx_q + IDX_W'(1);
			default:            rd_addr = '0;
		endcase
	end

	// Table write on a load item and registered read.
	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			x_mem[wr_addr] <= in_x;
			y_mem[wr_addr] <= in_y;
		end
		rd_x_q <= x_mem[rd_addr];
		rd_y_q <= y_mem[rd_addr];
	end

	// Last index in use, clamped from the written count.
	always_comb begin
		if (cfg_data == '0) begin
			last_d = '0;
		end else if (32'(cfg_data) > MAX_POINTS) begin
			last_d = IDX_W'(MAX_POINTS - 1);
		end else begin
			last_d = IDX_W'(cfg_data - pli_pkg::CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (cfg_valid) begin
			last_q <= last_d;
		end
	end

	// Segment differences and magnitude of the y step.
	always_comb begin
		num_w = {query_q[W-1], query_q} - {prev_x_q[W-1], prev_x_q};
		den_w = {cur_x_q[W-1], cur_x_q} - {prev_x_q[W-1], prev_x_q};
		dy_w  = {cur_y_q[W-1], cur_y_q} - {prev_y_q[W-1], prev_y_q};
		mag_w = dy_w[W] ? (~dy_w + (W+1)'(1)) : dy_w;
	end

	assign trial = {rem_q, dvd_q[W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	// Query capture, scan, multiply and divide registers.
	always_ff @(posedge clk) begin
		if (cmd.cap_query) begin
			query_q <= in_query;
		end
		if (cmd.take_clamp) begin
			prev_y_q <= rd_y_q;
			dvd_q    <= '0;
			neg_q    <= 1'b0;
		end
		if (cmd.scan_start || cmd.scan_step) begin
			prev_x_q <= rd_x_q;
			prev_y_q <= rd_y_q;
		end
		if (cmd.scan_start) begin
			idx_q <= IDX_W'(1);
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.scan_stop) begin
			cur_x_q <= rd_x_q;
			cur_y_q <= rd_y_q;
		end
		if (cmd.diff) begin
			num_q <= num_w[W-1:0];
			den_q <= den_w[W-1:0];
			mag_q <= mag_w[W-1:0];
			neg_q <= dy_w[W];
		end
		if (cmd.mul) begin
			{rem_q, dvd_q} <= num_q * mag_q;
			div_cnt_q      <= '0;
		end
		if (cmd.div_step) begin
			rem_q     <= fits ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
			dvd_q     <= {dvd_q[W-2:0], fits};
			div_cnt_q <= div_cnt_q + pli_pkg::DIV_CNT_W'(1);
		end
		if (cmd.finish) begin
			res_q <= neg_q ? (prev_y_q - dvd_q) : (prev_y_q + dvd_q);
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q;

	// Status toward the controller.
	always_comb begin
		sts.in_valid  = s_tvalid;
		sts.is_eval   = (s_tuser == pli_pkg::OP_EVAL);
		sts.ge_last   = (query_q >= rd_x_q);
		sts.le_first  = (query_q <= rd_x_q);
		sts.scan_done = (idx_q == last_q) || (rd_x_q >= query_q);
		sts.div_done  = (div_cnt_q == pli_pkg::DIV_CNT_W'(pli_pkg::DIV_STEPS - 1));
		sts.out_busy  = out_valid_q && !m_tready;
	end

endmodule

// ===== hdl/piecewise_linear_interpolator.sv =====
// An evaluate item gives the last y when the query is at or above the last x, the first y
// when it is at or below the first x, and otherwise the value interpolated on the segment
// whose upper breakpoint the scan finds. The input takes the next item only after the result
// is registered, so an evaluate holds the input until then and a load does not; a stalled
// result holds it longer.
// Reset clears control state and sets the count to one; the tables stay unknown until loaded.
`timescale 1ns / 1ps

module piecewise_linear_interpolator #(
	parameter int unsigned MAX_POINTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// From bit 0: entry_index[3:0], entry_x[35:4], entry_y[67:36],
	// query_x[99:68], zero padding[103:100].
	input  logic [pli_pkg::IN_DATA_W-1:0] s_tdata,
	// Bit 0: opcode.
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// Bits 31:0: result_y.
	output logic [pli_pkg::VAL_W-1:0]     m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pli_pkg::CNT_W-1:0]     cfg_data
);

	pli_pkg::cmd_t cmd;
	pli_pkg::sts_t sts;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	pli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (s_tready)
	);

	pli_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser[0]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== hdl/pli_checker.sv =====
// Port-level checks for the piecewise linear interpolator and their binding.
`timescale 1ns / 1ps

module pli_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [0:0]                    s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pli_pkg::VAL_W-1:0]     m_tdata
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed or dropped");

	// Once an evaluate item is taken, the input is no longer ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser[0] == pli_pkg::OP_EVAL)) |=> !s_tready)
		else $error("input ready during evaluation");

	// A load item leaves the input ready for the next item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser[0] == pli_pkg::OP_LOAD)) |=> s_tready)
		else $error("input stalled after a load item");

	// No result can appear in the cycle right after an evaluate is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser[0] == pli_pkg::OP_EVAL)) |=> !$rose(m_tvalid))
		else $error("result appeared too early");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
